// File: rtl/ens_pkg.sv
// ----------------------------------------------------------------------------
// ens_pkg
// Types and constants shared by the extent node scanner: item layouts,
// result status codes and node format constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ens_pkg;

  localparam int unsigned MAGIC_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned BLOCK_W = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned START_W = 48;
  localparam int unsigned PHYS_W  = 49;

  // extent length above this marks an uninitialized extent
  localparam logic [LEN_W-1:0]   UNINIT_LEN  = 16'd32768;
  localparam logic [MAGIC_W-1:0] RESET_MAGIC = 16'hF30A;

  // item kinds
  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_ENTRY  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_MAPPED   = 2'd0;
  localparam logic [1:0] ST_HOLE     = 2'd1;
  localparam logic [1:0] ST_DESCEND  = 2'd2;
  localparam logic [1:0] ST_BADMAGIC = 2'd3;

  typedef struct packed {
    logic               func;
    logic [MAGIC_W-1:0] magic;
    logic [COUNT_W-1:0] entry_count;
    logic [15:0]        depth;
    logic [BLOCK_W-1:0] key_block;
    logic [BLOCK_W-1:0] entry_first;
    logic [LEN_W-1:0]   entry_len;
    logic [START_W-1:0] entry_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PHYS_W-1:0] phys_block;
  } out_item_t;

endpackage : ens_pkg

`default_nettype wire

// File: rtl/extent_node_scanner_unit.sv
// ----------------------------------------------------------------------------
// extent_node_scanner_unit
// Scans one extent tree node (header item, then one item per entry) for a
// sought logical block and reports mapped block, hole, child or bad magic.
// ----------------------------------------------------------------------------
// a result is registered as the item that causes it is accepted, into the
//   output register, or into the skid stage while the output waits
// throughput: one item per cycle with the skid empty, set by the compare/add
//   path of one entry; a one-deep skid keeps input flowing while a result waits
// reset (rst, synchronous): scan waits for a header, skid and output empty,
//   expected magic back to 0xF30A
`default_nettype none

module extent_node_scanner_unit
  import ens_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration: expected node magic
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data,
  // input items
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire in_item_t     in_item,
  // result items
  output logic              out_valid,
  input  wire logic         out_stall,
  output out_item_t         out_item
);

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a header
    S_LEAF,   // scanning leaf extents
    S_INDEX,  // scanning index entries
    S_DRAIN   // result given, swallowing the rest of the node
  } scan_mode_t;

  // scan state
  scan_mode_t           scan_mode;
  logic [COUNT_W-1:0]   entries_left;
  logic [BLOCK_W-1:0]   sought_block;
  logic [START_W-1:0]   best_child;
  logic                 child_found;
  logic [MAGIC_W-1:0]   expected_magic;

  // output register and skid stage
  logic                 skid_valid;
  out_item_t            skid_item;

  // next values
  scan_mode_t           scan_mode_next;
  logic [COUNT_W-1:0]   entries_left_next;
  logic [BLOCK_W-1:0]   sought_block_next;
  logic [START_W-1:0]   best_child_next;
  logic                 child_found_next;

  // result of the accepted item
  logic                 res_valid;
  out_item_t            res_item;

  // entry datapath
  logic                 accept;
  logic                 take;
  logic                 is_last;
  logic [LEN_W-1:0]     len_adj;
  logic [BLOCK_W:0]     end_sum;
  logic                 key_ge;
  logic                 key_covered;
  logic [BLOCK_W-1:0]   offset;
  logic [PHYS_W-1:0]    mapped_blk;

  assign cfg_ready = 1'b1;
  // skid full means one result would have nowhere to go
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;

  // uninitialized extents carry the flag in the top of the length
  assign len_adj     = (in_item.entry_len > UNINIT_LEN) ?
                       (in_item.entry_len - UNINIT_LEN) : in_item.entry_len;
  // range end kept at 33 bits so first + len never wraps
  assign end_sum     = {1'b0, in_item.entry_first} +
                       {{(BLOCK_W + 1 - LEN_W){1'b0}}, len_adj};
  assign key_ge      = sought_block >= in_item.entry_first;
  assign key_covered = key_ge && ({1'b0, sought_block} < end_sum);
  assign offset      = sought_block - in_item.entry_first;
  assign mapped_blk  = {{(PHYS_W - START_W){1'b0}}, in_item.entry_start} +
                       {{(PHYS_W - BLOCK_W){1'b0}}, offset};
  // entries_left is never zero outside idle, so this is the final entry
  assign is_last     = entries_left == {{(COUNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    scan_mode_next      = scan_mode;
    entries_left_next   = entries_left;
    sought_block_next   = sought_block;
    best_child_next     = best_child;
    child_found_next    = child_found;
    res_valid           = 1'b0;
    res_item.status     = ST_HOLE;
    res_item.phys_block = '0;

    if (accept) begin
      if (in_item.func == FUNC_HEADER) begin
        // a header always restarts the scan
        scan_mode_next    = S_IDLE;
        entries_left_next = '0;
        best_child_next   = '0;
        child_found_next  = 1'b0;
        sought_block_next = in_item.key_block;
        if (in_item.magic != expected_magic) begin
          res_valid       = 1'b1;
          res_item.status = ST_BADMAGIC;
        end else if (in_item.entry_count == '0) begin
          res_valid       = 1'b1;
          res_item.status = ST_HOLE;
        end else begin
          entries_left_next = in_item.entry_count;
          scan_mode_next    = (in_item.depth == '0) ? S_LEAF : S_INDEX;
        end
      end else if (scan_mode != S_IDLE) begin
        // stray entries while idle fall through untouched
        entries_left_next = entries_left - {{(COUNT_W-1){1'b0}}, 1'b1};
        if (is_last) begin
          scan_mode_next = S_IDLE;
        end
        case (scan_mode)
          S_LEAF: begin
            if (key_covered) begin
              res_valid           = 1'b1;
              res_item.status     = ST_MAPPED;
              res_item.phys_block = mapped_blk;
              if (!is_last) begin
                scan_mode_next = S_DRAIN;
              end
            end else if (is_last) begin
              res_valid       = 1'b1;
              res_item.status = ST_HOLE;
            end
          end
          S_INDEX: begin
            if (key_ge) begin
              best_child_next  = in_item.entry_start;
              child_found_next = 1'b1;
              if (is_last) begin
                res_valid           = 1'b1;
                res_item.status     = ST_DESCEND;
                res_item.phys_block = {{(PHYS_W - START_W){1'b0}},
                                       in_item.entry_start};
              end
            end else begin
              // first entry past the key closes the search
              if (!is_last) begin
                scan_mode_next = S_DRAIN;
              end
              res_valid = 1'b1;
              if (child_found) begin
                res_item.status     = ST_DESCEND;
                res_item.phys_block = {{(PHYS_W - START_W){1'b0}}, best_child};
              end else begin
                res_item.status = ST_HOLE;
              end
            end
          end
          default: begin
            // draining: count only
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= S_IDLE;
      entries_left   <= '0;
      sought_block   <= '0;
      best_child     <= '0;
      child_found    <= 1'b0;
      expected_magic <= RESET_MAGIC;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      scan_mode    <= scan_mode_next;
      entries_left <= entries_left_next;
      sought_block <= sought_block_next;
      best_child   <= best_child_next;
      child_found  <= child_found_next;
      if (cfg_valid && cfg_ready) begin
        expected_magic <= cfg_data;
      end
      if (skid_valid) begin
        // no item is accepted while the skid holds a result
        if (take) begin
          out_item   <= skid_item;
          skid_valid <= 1'b0;
        end
      end else if (out_valid && !take) begin
        if (res_valid) begin
          skid_item  <= res_item;
          skid_valid <= 1'b1;
        end
      end else begin
        out_valid <= res_valid;
        out_item  <= res_item;
      end
    end
  end

`ifndef SYNTH
  // the skid only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result with empty output register");

  // entry count and scan mode agree
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (scan_mode == S_IDLE) == (entries_left == '0))
    else $error("entry count out of step with scan mode");

  // best child is only loaded together with its found flag
  a_child_flag: assert property (@(posedge clk) disable iff (rst)
    !child_found |-> (best_child == '0))
    else $error("best child set without found flag");

  // a bad header always leaves a result behind
  a_badmagic_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.func == FUNC_HEADER && in_item.magic != expected_magic)
      |=> out_valid)
    else $error("bad magic header gave no result");
`endif

endmodule : extent_node_scanner_unit

`default_nettype wire

// File: bench/tb_extent_node_scanner_unit.sv
// ----------------------------------------------------------------------------
// tb_extent_node_scanner_unit
// Self-checking bench for the extent node scanner. Header and entry items go
// in through the stall handshake, with random gaps on the input side and
// random stalls on the result side. An item-level model of the node scan
// works out each expected result as the items go in, and a checker compares
// every result item field by field against the oldest one still due. The
// expected node magic is set to several values over the run, the extremes
// among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_extent_node_scanner_unit;
  import ens_pkg::*;

  // generous bound: ~1000 items, each with worst gap plus worst result stall
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // idle cycles added once every due result is out
  localparam int unsigned SETTLE_CYCLES = 4;

  // where the scan stands between items
  typedef enum logic [1:0] {AWAIT_HEADER, IN_LEAF, IN_INDEX, SKIPPING} scan_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  // scan state mirrored by the bench
  logic [15:0] model_magic    = RESET_MAGIC;
  scan_mode_t  model_mode     = AWAIT_HEADER;
  logic [15:0] model_left     = '0;
  logic [31:0] model_key      = '0;
  logic [47:0] model_child    = '0;
  logic        model_child_ok = 1'b0;

  out_item_t   lookups_due[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  // when set, neither side idles: back-to-back items and results
  bit          no_gaps     = 1'b0;

  extent_node_scanner_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // scan model
  // ---------------------------------------------------------------------------

  function automatic void post_result(input logic [1:0] st, input logic [48:0] blk);
    out_item_t r;
    r.status     = st;
    r.phys_block = blk;
    lookups_due.push_back(r);
  endfunction

  // advances the mirrored scan by one accepted item, queueing any result
  function automatic void lookup_step(input in_item_t it);
    scan_mode_t  was;
    logic        last;
    logic [15:0] span;
    logic [32:0] span_end;
    if (it.func == FUNC_HEADER) begin
      // any header drops whatever scan was open
      model_mode     = AWAIT_HEADER;
      model_left     = '0;
      model_child    = '0;
      model_child_ok = 1'b0;
      model_key      = it.key_block;
      if (it.magic != model_magic) begin
        post_result(ST_BADMAGIC, '0);
      end else if (it.entry_count == '0) begin
        post_result(ST_HOLE, '0);
      end else begin
        model_left = it.entry_count;
        model_mode = (it.depth == '0) ? IN_LEAF : IN_INDEX;
      end
      return;
    end
    // entry with no header open is dropped
    if (model_mode == AWAIT_HEADER) return;
    was = model_mode;
    if (model_left != '0) model_left = model_left - 16'd1;
    last = (model_left == '0);
    if (last) model_mode = AWAIT_HEADER;
    if (was == SKIPPING) return;
    if (was == IN_LEAF) begin
      span = it.entry_len;
      if (span > UNINIT_LEN) span = span - UNINIT_LEN;
      // 33-bit end of range so the top of the block space does not wrap
      span_end = {1'b0, it.entry_first} + {17'd0, span};
      if (model_key >= it.entry_first && {1'b0, model_key} < span_end) begin
        if (!last) model_mode = SKIPPING;
        post_result(ST_MAPPED, {1'b0, it.entry_start} + {17'd0, model_key - it.entry_first});
      end else if (last) begin
        post_result(ST_HOLE, '0);
      end
      return;
    end
    // index node: keep the last entry at or below the key
    if (model_key >= it.entry_first) begin
      model_child    = it.entry_start;
      model_child_ok = 1'b1;
      if (!last) return;
    end else if (!last) begin
      model_mode = SKIPPING;
    end
    if (model_child_ok) post_result(ST_DESCEND, {1'b0, model_child});
    else post_result(ST_HOLE, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers and item builders
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // keys near both ends of the block space show up often
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 40);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // every field random, don't-care fields included
  function automatic in_item_t noise_item();
    in_item_t it;
    it.func        = 1'($urandom_range(0, 1));
    it.magic       = 16'($urandom);
    it.entry_count = 16'($urandom);
    it.depth       = 16'($urandom);
    it.key_block   = $urandom;
    it.entry_first = $urandom;
    it.entry_len   = 16'($urandom);
    it.entry_start = rand48();
    return it;
  endfunction

  function automatic in_item_t header_item(input logic [15:0] magic, input logic [15:0] count,
                                           input logic [15:0] depth, input logic [31:0] key);
    in_item_t it;
    it             = noise_item();
    it.func        = FUNC_HEADER;
    it.magic       = magic;
    it.entry_count = count;
    it.depth       = depth;
    it.key_block   = key;
    return it;
  endfunction

  function automatic in_item_t entry_item(input logic [31:0] first, input logic [15:0] len,
                                          input logic [47:0] start);
    in_item_t it;
    it             = noise_item();
    it.func        = FUNC_ENTRY;
    it.entry_first = first;
    it.entry_len   = len;
    it.entry_start = start;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------

  // valid stays high on return so the next item can follow back to back
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lookup_step(it);
  endtask

  // stop sending and wait for every due result, then some idle cycles
  task automatic drain_results(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (lookups_due.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_magic(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_magic = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("cycle %0d: mismatch on %s: got %0h, want %0h", cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, and the checker
  // ---------------------------------------------------------------------------

  initial begin : sink_stall
    int n;
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (n == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (lookups_due.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item), '0);
      end else begin
        want = lookups_due.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 64'(out_item.status), 64'(want.status));
        if (out_item.phys_block !== want.phys_block)
          report_mismatch("phys_block", 64'(out_item.phys_block), 64'(want.phys_block));
      end
    end
  end

  // hung run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_header_cases();
    // wrong magic is rejected at once
    send_item(header_item(16'h0000, 16'd3, 16'd0, 32'd7));
    // good magic but no entries: hole at once
    send_item(header_item(RESET_MAGIC, 16'd0, 16'hFFFF, 32'd7));
    // entry with no header open is dropped
    send_item(entry_item(32'd7, 16'd1, 48'd1));
  endtask

  task automatic test_leaf_lookup();
    // second extent is uninitialized and covers the key; third is skipped
    send_item(header_item(RESET_MAGIC, 16'd3, 16'd0, 32'd100));
    send_item(entry_item(32'd200, 16'd5, 48'h10));
    send_item(entry_item(32'd90, UNINIT_LEN + 16'd20, 48'h1000));
    send_item(entry_item(32'd100, 16'd1, 48'h2000));
    // range end past 2^32 and mapped block past 2^48
    send_item(header_item(RESET_MAGIC, 16'd1, 16'd0, 32'hFFFF_FFFF));
    send_item(entry_item(32'hFFFF_FFF0, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
    // length of exactly 32768 is a full initialized extent
    send_item(header_item(RESET_MAGIC, 16'd1, 16'd0, 32'd32767));
    send_item(entry_item(32'd0, UNINIT_LEN, 48'h40));
    // zero length and a range ending right at the key: hole at the last entry
    send_item(header_item(RESET_MAGIC, 16'd2, 16'd0, 32'd5));
    send_item(entry_item(32'd5, 16'd0, 48'h1));
    send_item(entry_item(32'd0, 16'd5, 48'h2));
  endtask

  task automatic test_index_descent();
    // child comes out at the first entry past the key; the rest is skipped
    send_item(header_item(RESET_MAGIC, 16'd4, 16'hFFFF, 32'd50));
    send_item(entry_item(32'd0, 16'd0, 48'hA));
    send_item(entry_item(32'd40, 16'd0, 48'hB));
    send_item(entry_item(32'd60, 16'd0, 48'hC));
    send_item(entry_item(32'd70, 16'd0, 48'hD));
    // every entry passes: child given at the end of the node
    send_item(header_item(RESET_MAGIC, 16'd1, 16'd1, 32'hFFFF_FFFF));
    send_item(entry_item(32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
    // first entry already past the key: hole, then the rest is skipped
    send_item(header_item(RESET_MAGIC, 16'd2, 16'd1, 32'd5));
    send_item(entry_item(32'd6, 16'd0, 48'h5));
    send_item(entry_item(32'd0, 16'd0, 48'h6));
  endtask

  task automatic test_abandoned_scan();
    // a long leaf scan cut short by a new header with a wrong magic
    send_item(header_item(RESET_MAGIC, 16'hFFFF, 16'd0, 32'd1000));
    send_item(entry_item(32'd0, 16'd10, 48'd0));
    send_item(header_item(16'hFFFF, 16'd1, 16'd0, 32'd0));
    // nothing open any more
    send_item(entry_item(32'd0, 16'd1, 48'd0));
  endtask

  // one random node, or some noise; sent counts the items that matter
  task automatic send_random_node(inout int sent);
    logic [31:0] key;
    logic [31:0] first;
    logic [15:0] count;
    logic [15:0] depth;
    logic [15:0] len;
    int          kind;
    int          n;
    bit          leaf;
    kind = $urandom_range(0, 99);
    key  = pick_key();
    if (kind < 8) begin
      send_item(header_item(model_magic ^ 16'($urandom_range(1, 65535)), 16'($urandom),
                            16'($urandom), key));
      sent++;
      return;
    end
    if (kind < 14) begin
      // stray entries and fully random items
      n = $urandom_range(1, 3);
      repeat (n) send_item(noise_item());
      return;
    end
    leaf = ($urandom_range(0, 1) == 0);
    if (leaf) depth = 16'd0;
    else if ($urandom_range(0, 3) == 0) depth = 16'hFFFF;
    else depth = 16'($urandom_range(1, 65535));
    // broken nodes claim any count and get cut short by the next header
    if (kind < 24) count = 16'($urandom);
    else if (kind < 34) count = 16'($urandom_range(7, 24));
    else count = 16'($urandom_range(1, 6));
    send_item(header_item(model_magic, count, depth, key));
    sent++;
    n = (kind < 24) ? $urandom_range(0, 5) : int'(count);
    first = key - $urandom_range(0, 120);
    for (int i = 0; i < n; i++) begin
      if (leaf) begin
        // mostly extents that start just below the key
        first = ($urandom_range(0, 3) == 0) ? $urandom : key - $urandom_range(0, 40);
        len   = 16'($urandom_range(0, 60));
        if ($urandom_range(0, 2) == 0) len = len + UNINIT_LEN;
        if ($urandom_range(0, 9) == 0) len = 16'($urandom);
      end else begin
        // index entries climb past the key
        first = ($urandom_range(0, 6) == 0) ? $urandom : first + $urandom_range(0, 60);
        len   = 16'($urandom);
      end
      send_item(entry_item(first, len, rand48()));
      sent++;
    end
  endtask

  task automatic test_random_nodes(input int target);
    int sent;
    int last_pause;
    sent       = 0;
    last_pause = 0;
    while (sent < target) begin
      // now and then a node with no idling on either side
      no_gaps = ($urandom_range(0, 7) == 0);
      send_random_node(sent);
      // hold off until the block has caught up
      if (sent - last_pause >= 120) begin
        drain_results(0);
        last_pause = sent;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_magic_settings();
    logic [15:0] magic_values [4];
    magic_values = '{16'h0000, 16'hFFFF, 16'($urandom), RESET_MAGIC};
    foreach (magic_values[i]) begin
      // register only changes with the block idle
      drain_results(SETTLE_CYCLES);
      write_magic(magic_values[i]);
      test_random_nodes(150);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_header_cases();
    test_leaf_lookup();
    test_index_descent();
    test_abandoned_scan();
    test_random_nodes(250);
    test_magic_settings();
    drain_results(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
